// ----- rtl/sspan_pkg.sv -----
// ----------------------------------------------------------------------------
// sspan_pkg
// Types and fixed widths shared by the stock span block.
// ----------------------------------------------------------------------------
package sspan_pkg;

  localparam int PRICE_IN_W = 32;
  localparam int SPAN_W     = 11;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_EMIT
  } sspan_state_t;

endpackage

// ----- rtl/stock_span_monotonic_stack.sv -----
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack
// Stock span of a price stream, computed with a monotonic stack held in RAM.
// ----------------------------------------------------------------------------
// One price beat is taken at a time, and s_tready stays low until its result
// has been loaded into the output register. A beat goes straight to the emit
// state when the stack is empty or the run is too long; otherwise the top entry
// is read, and the compare state pops entries until one holds a higher price or
// the stack is empty, and then the beat is emitted. The pace is set by the
// single read port of the stack RAM and the one price comparator, which test
// one stacked entry per cycle. Each entry is pushed once and popped at most
// once. The stack RAM needs no clearing pass after reset.
module stock_span_monotonic_stack #(
  parameter int MAX_LEN     = 1024,
  parameter int PRICE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sspan_pkg::PRICE_IN_W-1:0] s_tdata,  // [31:0] price
  input  logic                            s_tuser,  // [0] first
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sspan_pkg::OUT_DATA_W-1:0] m_tdata,  // [10:0] span, zero above
  output logic                            m_tuser   // [0] too_long
);

  import sspan_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int DW = $clog2(MAX_LEN + 1);
  localparam int PW = $clog2(MAX_LEN + 2);
  localparam int EW = PRICE_WIDTH + PW;

  localparam logic [PRICE_WIDTH-1:0] SIGN_BIT = {1'b1, {(PRICE_WIDTH-1){1'b0}}};
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_LEN);
  localparam logic [PW-1:0] POS_MAX   = PW'(MAX_LEN);
  localparam logic [PW-1:0] POS_OVER  = PW'(MAX_LEN + 1);

  sspan_state_t state, state_next;

  logic [DW-1:0]          depth;
  logic [PW-1:0]          pos;
  logic [PRICE_WIDTH-1:0] key;
  logic [PW-1:0]          span;
  logic                   too_long;

  logic [EW-1:0] mem [MAX_LEN];
  logic [EW-1:0] rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic                   in_beat;
  logic                   out_free;
  logic [PW-1:0]          pos_cur;
  logic [DW-1:0]          depth_cur;
  logic [PRICE_WIDTH-1:0] key_in;
  logic                   over;
  logic [PRICE_WIDTH-1:0] top_key;
  logic [PW-1:0]          top_pos;
  logic                   pop;
  logic [DW-1:0]          depth_dec;
  logic [DW-1:0]          depth_dec2;

  assign in_beat    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign pos_cur    = s_tuser ? '0 : pos;
  assign depth_cur  = s_tuser ? '0 : depth;
  assign key_in     = PRICE_WIDTH'(s_tdata) ^ SIGN_BIT;
  assign over       = (pos_cur >= POS_MAX);
  assign top_key    = rd_data[EW-1:PW];
  assign top_pos    = rd_data[PW-1:0];
  assign pop        = (top_key <= key);
  assign depth_dec  = depth - DW'(1);
  assign depth_dec2 = depth - DW'(2);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          if (over || depth_cur == '0) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (!pop || depth == DW'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = depth_dec[AW-1:0];
    wr_en    = 1'b0;
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_READ: rd_en = 1'b1;
      S_CMP: begin
        rd_en   = pop && depth != DW'(1);
        rd_addr = depth_dec2[AW-1:0];
      end
      S_EMIT: wr_en = out_free && !too_long && depth < DEPTH_MAX;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[depth[AW-1:0]] <= {key, pos};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      depth    <= '0;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            key   <= key_in;
            depth <= depth_cur;
            if (over) begin
              pos      <= POS_OVER;
              span     <= '0;
              too_long <= 1'b1;
            end else begin
              pos      <= pos_cur + PW'(1);
              span     <= pos_cur + PW'(1);
              too_long <= 1'b0;
            end
          end
        end
        S_CMP: begin
          if (pop) begin
            depth <= depth_dec;
            span  <= pos;
          end else begin
            span  <= pos - top_pos;
          end
        end
        S_EMIT: begin
          if (wr_en) begin
            depth <= depth + DW'(1);
          end
        end
        default: depth <= depth;
      endcase
      if (state == S_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_tdata <= {(OUT_DATA_W - SPAN_W)'(0), SPAN_W'(span)};
      m_tuser <= too_long;
    end
  end

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_MAX)
    else $error("stack depth beyond capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_OVER)
    else $error("day position beyond saturation");

  a_cmp_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (depth != '0))
    else $error("compare on empty stack");

  a_too_long_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("span not zero on too_long beat");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (m_tvalid && state == S_IDLE))
    else $error("result not loaded on emit");
`endif

endmodule

// ----- bench/span_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// span_checker
// Watches both streams of the stock span block, predicts the span of every
// accepted price beat with a stack of its own, and compares each result beat,
// field by field, with the oldest prediction. The failure count and the number
// of results still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module span_checker #(
  parameter int MAX_LEN = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [sspan_pkg::PRICE_IN_W-1:0] s_tdata,   // [31:0] price
  input  logic                             s_tuser,   // [0] first
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [sspan_pkg::OUT_DATA_W-1:0] m_tdata,   // [10:0] span, zero above
  input  logic                             m_tuser,   // [0] too_long
  output int                               errors,
  output int                               pending
);
  import sspan_pkg::*;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic              too_long;
  } span_beat_t;

  logic signed [PRICE_IN_W-1:0] ladder_price [MAX_LEN];
  int unsigned                  ladder_day   [MAX_LEN];
  int unsigned                  ladder_depth = 0;
  int unsigned                  day_no       = 0;
  int                           fail_count   = 0;
  span_beat_t                   span_due [$];

  function automatic span_beat_t next_span(input logic signed [PRICE_IN_W-1:0] price,
                                           input logic restart);
    span_beat_t  res;
    int unsigned reach;
    res = '0;
    if (restart) begin
      ladder_depth = 0;
      day_no       = 0;
    end
    if (day_no >= MAX_LEN) begin
      day_no       = MAX_LEN + 1;
      res.too_long = 1'b1;
      return res;
    end
    day_no++;
    while (ladder_depth > 0 && ladder_price[ladder_depth - 1] <= price)
      ladder_depth--;
    reach = (ladder_depth == 0) ? day_no : day_no - ladder_day[ladder_depth - 1];
    if (ladder_depth < MAX_LEN) begin
      ladder_price[ladder_depth] = price;
      ladder_day[ladder_depth]   = day_no;
      ladder_depth++;
    end
    res.span = reach[SPAN_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    span_beat_t want;
    if (rst) begin
      span_due.delete();
      ladder_depth = 0;
      day_no       = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (span_due.size() == 0) begin
          $error("unexpected result beat: span %0d, too_long %0b",
                 m_tdata[SPAN_W-1:0], m_tuser);
          fail_count++;
        end else begin
          want = span_due.pop_front();
          if (m_tdata[SPAN_W-1:0] !== want.span) begin
            $error("span: expected %0d, actual %0d", want.span, m_tdata[SPAN_W-1:0]);
            fail_count++;
          end
          if (m_tdata[OUT_DATA_W-1:SPAN_W] !== '0) begin
            $error("span padding: expected 0, actual %0h", m_tdata[OUT_DATA_W-1:SPAN_W]);
            fail_count++;
          end
          if (m_tuser !== want.too_long) begin
            $error("too_long: expected %0b, actual %0b", want.too_long, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        span_due.insert(span_due.size(), next_span(s_tdata, s_tuser));
    end
    errors  <= fail_count;
    pending <= span_due.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stock span block: a directed opening over price extremes,
// equal prices and a missing first flag after reset, then random sequences of
// varied shape.
// Both streams idle at random outside a calm stretch; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;
  import sspan_pkg::*;

  localparam int MAX_LEN      = 1024;
  localparam int RANDOM_BEATS = 720;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = MAX_LEN + 64;

  typedef enum int {WILD, NARROW, RISING, FALLING} price_shape_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PRICE_IN_W-1:0] s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  bit                    calm     = 1'b0;
  int                    errors;
  int                    pending;
  int                    quiet_cycles = 0;

  stock_span_monotonic_stack #(
    .MAX_LEN     (MAX_LEN),
    .PRICE_WIDTH (PRICE_IN_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  span_checker #(
    .MAX_LEN (MAX_LEN)
  ) span_chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [PRICE_IN_W-1:0] price, input logic first);
    while (!calm && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= price;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the input until every result due has come out
  task automatic await_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_run(input int len, input price_shape_t shape);
    int level;
    int price;
    level = $urandom;
    for (int i = 0; i < len; i++) begin
      case (shape)
        WILD:    price = $urandom;
        NARROW:  price = $signed($urandom_range(16)) - 8;
        RISING:  begin
          level += $urandom_range(3);
          price = level;
        end
        default: begin
          level -= $urandom_range(3);
          price = level;
        end
      endcase
      if (shape != WILD && $urandom_range(7) == 0)
        price = $urandom;
      send_beat(price, i == 0);
    end
  endtask

  initial begin
    int sent;
    int runs;
    int len;
    sent = 0;
    runs = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_beat(32'd0, 1'b0);
    send_beat(32'd100, 1'b0);
    send_beat(32'd100, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'd1, 1'b0);
    send_beat(32'h8000_0000, 1'b1);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'd100, 1'b1);
    send_beat(32'd80, 1'b0);
    send_beat(32'd60, 1'b0);
    send_beat(32'd70, 1'b0);
    send_beat(32'd60, 1'b0);
    send_beat(32'd75, 1'b0);
    send_beat(32'd85, 1'b0);
    send_beat(-32'sd5, 1'b1);
    send_beat(-32'sd6, 1'b0);
    send_beat(-32'sd5, 1'b0);
    send_beat(32'h5555_5555, 1'b0);
    send_beat(32'hAAAA_AAAA, 1'b0);
    await_results();

    while (sent < RANDOM_BEATS) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      calm = (sent >= 250 && sent < 400);
      send_run(len, price_shape_t'($urandom_range(3)));
      sent += len;
      runs++;
      if (runs == 3 || $urandom_range(15) == 0)
        await_results();
    end
    calm = 1'b0;

    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
